// ----- design/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define MLR_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("%m: assertion failed");

// implication checked on every clock edge, reset included
`define MLR_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
	else $error("%m: assertion failed");

`endif

// ----- design/mlr_pkg.sv -----
// shared widths, codes and types of the midpoint line rasterizer
package mlr_pkg;

	localparam int CW   = 12;     // coordinate bits
	localparam int COLW = 8;      // color bits
	localparam int DW   = CW + 4; // decision and increment bits

	localparam int S_DATA_W = ((4 * CW + COLW + 7) / 8) * 8;
	localparam int M_DATA_W = ((2 * CW + COLW + 7) / 8) * 8;

	// item kind carried in tuser
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	typedef struct packed {
		logic [CW-1:0]        cur_x;
		logic [CW-1:0]        cur_y;
		logic [CW-1:0]        major_end;
		logic signed [DW-1:0] decision;
		logic signed [DW-1:0] inc_straight;
		logic signed [DW-1:0] inc_up;
		logic signed [DW-1:0] inc_down;
		logic                 major_is_second;
		logic                 minor_falls;
	} line_params_t;

endpackage

// ----- design/mlr_setup.sv -----
// line setup: major axis, endpoint order, decision value and increments
module mlr_setup (
	input  logic [mlr_pkg::CW-1:0] start_x,
	input  logic [mlr_pkg::CW-1:0] start_y,
	input  logic [mlr_pkg::CW-1:0] end_x,
	input  logic [mlr_pkg::CW-1:0] end_y,
	output mlr_pkg::line_params_t  setup
);
	import mlr_pkg::*;

	logic signed [CW:0] dx, dy, adx, ady, odx, ody, dmaj, dmin;
	logic signed [DW-1:0] dmaj_w, dmin_w;
	logic sec, swap;

	always_comb begin
		dx  = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
		dy  = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
		adx = dx[CW] ? -dx : dx;
		ady = dy[CW] ? -dy : dy;
		// ties go to the second axis
		sec  = !(adx > ady);
		swap = sec ? dy[CW] : dx[CW];
		odx  = swap ? -dx : dx;
		ody  = swap ? -dy : dy;
		dmaj = sec ? ody : odx;
		dmin = sec ? odx : ody;
		dmaj_w = {{(DW-CW-1){dmaj[CW]}}, dmaj};
		dmin_w = {{(DW-CW-1){dmin[CW]}}, dmin};

		setup.cur_x           = swap ? end_x : start_x;
		setup.cur_y           = swap ? end_y : start_y;
		setup.major_end       = sec ? (swap ? start_y : end_y) : (swap ? start_x : end_x);
		setup.major_is_second = sec;
		setup.minor_falls     = dmin[CW];
		setup.decision        = dmin[CW] ? ((dmin_w <<< 1) + dmaj_w)
		                                 : ((dmin_w <<< 1) - dmaj_w);
		setup.inc_up          = (dmin_w - dmaj_w) <<< 1;
		setup.inc_straight    = dmin_w <<< 1;
		setup.inc_down        = (dmin_w + dmaj_w) <<< 1;
	end

endmodule

// ----- design/mlr_step.sv -----
// one midpoint step: advance the major axis, maybe the minor axis
module mlr_step (
	input  mlr_pkg::line_params_t cur,
	output mlr_pkg::line_params_t nxt
);
	import mlr_pkg::*;

	logic                 move_minor;
	logic signed [DW-1:0] inc;
	logic [CW-1:0]        minor_adj;

	always_comb begin
		move_minor = cur.minor_falls ? (cur.decision <= 0) : (cur.decision > 0);
		if (!move_minor) begin
			inc = cur.inc_straight;
		end else if (cur.minor_falls) begin
			inc = cur.inc_down;
		end else begin
			inc = cur.inc_up;
		end
		minor_adj = cur.minor_falls ? {CW{1'b1}} : {{(CW-1){1'b0}}, 1'b1};

		nxt          = cur;
		nxt.decision = cur.decision + inc;
		if (!cur.major_is_second) begin
			nxt.cur_x = cur.cur_x + {{(CW-1){1'b0}}, 1'b1};
			if (move_minor) begin
				nxt.cur_y = cur.cur_y + minor_adj;
			end
		end else begin
			nxt.cur_y = cur.cur_y + {{(CW-1){1'b0}}, 1'b1};
			if (move_minor) begin
				nxt.cur_x = cur.cur_x + minor_adj;
			end
		end
	end

endmodule

// ----- design/midpoint_line_rasterizer.sv -----
// midpoint line rasterizer top level: input stage, line state, pixel output register
//
// Midpoint (Bresenham) line rasterizer for all octants. A start transaction
// (tuser low) loads two endpoints and a color and emits the first pixel; each
// step transaction (tuser high) emits the next pixel along the major axis,
// with tlast marking the line endpoint. A step while no line is active is
// consumed and emits nothing, and a start always drops any line in progress.
// The block takes one transaction per clock while m_tready is high and emits
// at most one pixel per clock; a pixel is shown on the master side after its
// transaction passes the input register and then the pixel register. The
// rate is set by the decision-value update, a single add and compare that
// closes on the line state register. The input register takes a new
// transaction while a pixel waits for m_tready, as long as it is empty.
module midpoint_line_rasterizer (
	input  logic                         clk,
	input  logic                         arst_n,
	// slave side
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// start_x, start_y, end_x, end_y, draw_color (lowest bit up)
	input  logic [mlr_pkg::S_DATA_W-1:0] s_tdata,
	// action
	input  logic                         s_tuser,
	// master side
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// pixel_x, pixel_y, pixel_color (lowest bit up), zero padded
	output logic [mlr_pkg::M_DATA_W-1:0] m_tdata,
	// last_pixel
	output logic                         m_tlast
);
	import mlr_pkg::*;

	// input stage
	logic            valid_s1;
	logic            action_s1;
	logic [CW-1:0]   ax_s1, ay_s1, bx_s1, by_s1;
	logic [COLW-1:0] color_s1;

	// line state
	line_params_t    params_q;
	logic            line_active_q;
	logic [COLW-1:0] held_color_q;

	// pixel output register
	logic            m_valid_q;
	logic [CW-1:0]   px_q, py_q;
	logic [COLW-1:0] pcolor_q;
	logic            plast_q;

	line_params_t    setup, stepped, params_nxt;
	logic            s_accept, advance, is_start, produce, last;
	logic [CW-1:0]   major_nxt;
	logic [COLW-1:0] color_nxt;

	mlr_setup u_setup (
		.start_x (ax_s1),
		.start_y (ay_s1),
		.end_x   (bx_s1),
		.end_y   (by_s1),
		.setup   (setup)
	);

	mlr_step u_step (
		.cur (params_q),
		.nxt (stepped)
	);

	// the input stage moves on whenever the pixel register is free or draining
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_accept = s_tvalid && s_tready;

	always_comb begin
		is_start   = (action_s1 == ACT_START);
		produce    = is_start || line_active_q;
		params_nxt = is_start ? setup : stepped;
		major_nxt  = params_nxt.major_is_second ? params_nxt.cur_y : params_nxt.cur_x;
		last       = (major_nxt == params_nxt.major_end);
		color_nxt  = is_start ? color_s1 : held_color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_accept) begin
			action_s1 <= s_tuser;
			ax_s1     <= s_tdata[CW-1:0];
			ay_s1     <= s_tdata[2*CW-1:CW];
			bx_s1     <= s_tdata[3*CW-1:2*CW];
			by_s1     <= s_tdata[4*CW-1:3*CW];
			color_s1  <= s_tdata[4*CW+COLW-1:4*CW];
		end
	end

	// line state, cleared to zero on reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			params_q      <= '0;
			line_active_q <= 1'b0;
			held_color_q  <= '0;
		end else if (advance && produce) begin
			params_q      <= params_nxt;
			line_active_q <= !last;
			held_color_q  <= color_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= produce;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// pixel payload
	always_ff @(posedge clk) begin
		if (advance && produce) begin
			px_q     <= params_nxt.cur_x;
			py_q     <= params_nxt.cur_y;
			pcolor_q <= color_nxt;
			plast_q  <= last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = M_DATA_W'({pcolor_q, py_q, px_q});
	assign m_tlast  = plast_q;

endmodule

// ----- design/mlr_checker.sv -----
// port-level checker for the midpoint line rasterizer, with its bind
`include "assert_macros.svh"

module mlr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [mlr_pkg::M_DATA_W-1:0] m_tdata,
	input logic                         m_tlast
);
	import mlr_pkg::*;

	// a stalled pixel holds its payload
	`MLR_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// no pixel is shown while reset is held
	`MLR_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_tvalid)

	// with no pixel pending the input side never stalls
	`MLR_ASSERT(a_ready_when_empty, clk, arst_n, !m_tvalid |-> s_tready)

	// a new pixel is always caused by a transaction accepted through the input register
	`MLR_ASSERT(a_pixel_has_cause, clk, arst_n, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (.*);
